// File: sv/assert_macros.svh
// assertion macros shared by the smoother rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mas_pkg.sv
// constants, tap tables and helper functions for the moving average smoother
// no dependencies
`default_nettype none

package mas_pkg;

  localparam int AVG_LEN    = 25;
  localparam int FRAC_BITS  = 8;
  localparam int SAMPLE_W   = 16;
  localparam int NEG_W      = SAMPLE_W + 1;
  localparam int NEG_MAX    = 32767;
  localparam int RATE_W     = 8;
  localparam int RATE_LIMIT = 60;
  localparam int OUT_W      = 25;
  localparam int OUT_LIMIT  = 8388608;
  localparam int SG_TAPS    = 9;
  localparam int HIST_LEN   = 4;
  localparam int TAP_W      = 8;

  // running sum and divide by window length
  localparam int SUM_W   = NEG_W + $clog2(AVG_LEN);
  localparam int AMAG_W  = SUM_W - 1 + FRAC_BITS;
  localparam int AVG_SH  = AMAG_W + $clog2(AVG_LEN);
  localparam int AVG_MW  = AMAG_W + 1;
  localparam logic [63:0] AVG_RECIP =
    ((64'd1 << AVG_SH) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN);
  localparam logic [AVG_MW-1:0] AVG_MUL = AVG_RECIP[AVG_MW-1:0];

  // smoothing filter, gain is the sum of absolute taps
  localparam int SG_S_GAIN = 315;
  localparam int SG_S_DIV  = 231;
  localparam int SMAG_W    = OUT_W - 2 + $clog2(SG_S_GAIN);
  localparam int ACC_S_W   = SMAG_W + 1;
  localparam int S_SH      = SMAG_W + $clog2(SG_S_DIV);
  localparam int S_MW      = SMAG_W + 1;
  localparam logic [63:0] S_RECIP =
    ((64'd1 << S_SH) + 64'(SG_S_DIV) - 64'd1) / 64'(SG_S_DIV);
  localparam logic [S_MW-1:0] S_MUL = S_RECIP[S_MW-1:0];

  // derivative filter
  localparam int SG_D_GAIN = 20;
  localparam int SG_D_DIV  = 60;
  localparam int DMAG_W    = OUT_W - 2 + $clog2(SG_D_GAIN);
  localparam int ACC_D_W   = DMAG_W + 1;
  localparam int D_SH      = DMAG_W + $clog2(SG_D_DIV);
  localparam int D_MW      = DMAG_W + 1;
  localparam logic [63:0] D_RECIP =
    ((64'd1 << D_SH) + 64'(SG_D_DIV) - 64'd1) / 64'(SG_D_DIV);
  localparam logic [D_MW-1:0] D_MUL = D_RECIP[D_MW-1:0];

  // index 0 is the newest mean
  localparam logic signed [TAP_W-1:0] SG_S_TAP [SG_TAPS] =
    '{-21, 14, 39, 54, 59, 54, 39, 14, -21};
  localparam logic signed [TAP_W-1:0] SG_D_TAP [SG_TAPS] =
    '{4, 3, 2, 1, 0, -1, -2, -3, -4};

  // saturate a quotient magnitude and apply the sign
  function automatic logic signed [OUT_W-1:0] sat_signed(input logic [63:0] q,
                                                          input logic neg);
    logic [OUT_W-1:0] m;
    m = (q > 64'(OUT_LIMIT)) ? OUT_W'(OUT_LIMIT) : q[OUT_W-1:0];
    return neg ? -m : m;
  endfunction

endpackage

`default_nettype wire

// File: sv/mas_in_if.sv
// sample request channel
// depends on mas_pkg
`default_nettype none

interface mas_in_if;
  import mas_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

`default_nettype wire

// File: sv/mas_out_if.sv
// result request channel
// depends on mas_pkg
`default_nettype none

interface mas_out_if;
  import mas_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] moving_average;
  logic signed [OUT_W-1:0] smoothed_delayed;
  logic signed [OUT_W-1:0] first_derivative;
  modport source (output valid, moving_average, smoothed_delayed, first_derivative,
                  input ready);
  modport sink (input valid, moving_average, smoothed_delayed, first_derivative,
                output ready);
endinterface

`default_nettype wire

// File: sv/mas_cfg_if.sv
// configuration write channel for the mean rate register
// depends on mas_pkg
`default_nettype none

interface mas_cfg_if;
  import mas_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] mean_rate_bpm;
  modport source (output valid, mean_rate_bpm, input ready);
  modport sink (input valid, mean_rate_bpm, output ready);
endinterface

`default_nettype wire

// File: sv/moving_average_savgol_smoother.sv
// top level of the moving average and savitzky-golay smoother
// depends on mas_pkg, the three channel interfaces, mas_sample_cell, mas_sg_cell
// and assert_macros.svh
//
// Takes one signed depth sample per cycle while the output is not stalled and
// returns one result per sample through the running sum, mean division,
// filter cell, filter division and output registers. Samples are negated
// with saturation and shifted through a row of window cells while a running
// sum forms the window mean; the means shift through a row of nine filter
// cells that build the smoothed value and the first derivative. Divisions by
// constants use reciprocal multipliers, each followed by a register. All
// stages advance together whenever the output register is empty or being
// taken, so a stall on the result side holds the input side. The rate
// register may only be written while no sample is in flight.
`default_nettype none
`include "assert_macros.svh"

module moving_average_savgol_smoother (
  input  logic      clk,
  input  logic      rst_n,
  mas_in_if.sink    in_ch,
  mas_out_if.source out_ch,
  mas_cfg_if.sink   cfg_ch
);
  import mas_pkg::*;

  localparam int APROD_W = AMAG_W + AVG_MW;
  localparam int SPROD_W = SMAG_W + S_MW;
  localparam int DPROD_W = DMAG_W + D_MW;

  logic en;
  logic take;

  // config
  logic [RATE_W-1:0] rate_r, rate_nxt;

  // sample window and running sum
  logic signed [NEG_W-1:0] s_ext, neg_full, neg_v;
  logic signed [NEG_W-1:0] sw [AVG_LEN+1];
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    a_v_r, a_v_nxt;

  // mean division
  logic [SUM_W-1:0]        sum_abs;
  logic [AMAG_W-1:0]       b_mag_r, b_mag_nxt;
  logic                    b_neg_r, b_neg_nxt, b_v_r, b_v_nxt;
  logic [APROD_W-1:0]      c_prod_r, c_prod_nxt;
  logic                    c_neg_r, c_neg_nxt, c_v_r, c_v_nxt;
  logic signed [OUT_W-1:0] d_mean_r, d_mean_nxt;
  logic                    d_v_r, d_v_nxt;

  // filter cells
  logic                      sg_shift;
  logic signed [ACC_S_W-1:0] cs [SG_TAPS+1];
  logic signed [ACC_D_W-1:0] cd [SG_TAPS+1];
  logic signed [OUT_W-1:0]   e_mean_r, e_mean_nxt;
  logic                      e_v_r, e_v_nxt;

  // filter divisions
  logic [SMAG_W-1:0]       f_s_mag_r, f_s_mag_nxt;
  logic [DMAG_W-1:0]       f_d_mag_r, f_d_mag_nxt;
  logic                    f_s_neg_r, f_s_neg_nxt, f_d_neg_r, f_d_neg_nxt;
  logic signed [OUT_W-1:0] f_mean_r, f_mean_nxt;
  logic                    f_v_r, f_v_nxt;
  logic [SPROD_W-1:0]      g_s_prod_r, g_s_prod_nxt;
  logic [DPROD_W-1:0]      g_d_prod_r, g_d_prod_nxt;
  logic                    g_s_neg_r, g_s_neg_nxt, g_d_neg_r, g_d_neg_nxt;
  logic signed [OUT_W-1:0] g_mean_r, g_mean_nxt;
  logic                    g_v_r, g_v_nxt;

  // history and output
  logic signed [OUT_W-1:0] smooth, deriv;
  logic                    h_shift;
  logic signed [OUT_W-1:0] hist_r [HIST_LEN];
  logic signed [OUT_W-1:0] hist_nxt [HIST_LEN];
  logic signed [OUT_W-1:0] out_avg_r, out_avg_nxt;
  logic signed [OUT_W-1:0] out_sm_r, out_sm_nxt;
  logic signed [OUT_W-1:0] out_dv_r, out_dv_nxt;
  logic                    out_v_r, out_v_nxt;

  assign en           = !out_v_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign take         = in_ch.valid && en;
  assign cfg_ch.ready = 1'b1;

  always_comb rate_nxt = cfg_ch.valid ? cfg_ch.mean_rate_bpm : rate_r;

  // negate with saturation
  always_comb begin
    s_ext    = NEG_W'(in_ch.sample);
    neg_full = -s_ext;
    neg_v    = (neg_full > NEG_W'(NEG_MAX)) ? NEG_W'(NEG_MAX) : neg_full;
  end

  assign sw[0] = neg_v;

  for (genvar g = 0; g < AVG_LEN; g++) begin : g_sample
    mas_sample_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (take),
      .d_in  (sw[g]),
      .q     (sw[g+1])
    );
  end

  always_comb begin
    sum_nxt = take ? sum_r + SUM_W'(neg_v) - SUM_W'(sw[AVG_LEN]) : sum_r;
    a_v_nxt = en ? take : a_v_r;
  end

  // mean = (sum << frac) / avg_len, truncated toward zero
  always_comb begin
    sum_abs    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    b_mag_nxt  = en ? (AMAG_W'(sum_abs) << FRAC_BITS) : b_mag_r;
    b_neg_nxt  = en ? sum_r[SUM_W-1] : b_neg_r;
    b_v_nxt    = en ? a_v_r : b_v_r;
    c_prod_nxt = en ? APROD_W'(b_mag_r) * APROD_W'(AVG_MUL) : c_prod_r;
    c_neg_nxt  = en ? b_neg_r : c_neg_r;
    c_v_nxt    = en ? b_v_r : c_v_r;
    d_mean_nxt = en ? sat_signed(64'(c_prod_r[APROD_W-1:AVG_SH]), c_neg_r) : d_mean_r;
    d_v_nxt    = en ? c_v_r : d_v_r;
  end

  assign sg_shift    = d_v_r && en;
  assign cs[SG_TAPS] = '0;
  assign cd[SG_TAPS] = '0;

  for (genvar g = 0; g < SG_TAPS; g++) begin : g_sg
    mas_sg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (sg_shift),
      .x        (d_mean_r),
      .tap_s    (SG_S_TAP[g]),
      .tap_d    (SG_D_TAP[g]),
      .acc_s_in (cs[g+1]),
      .acc_d_in (cd[g+1]),
      .acc_s    (cs[g]),
      .acc_d    (cd[g])
    );
  end

  // filter outputs divided by 231 and 60
  always_comb begin
    e_mean_nxt   = en ? d_mean_r : e_mean_r;
    e_v_nxt      = en ? d_v_r : e_v_r;
    f_s_mag_nxt  = en ? (cs[0][ACC_S_W-1] ? SMAG_W'(-cs[0]) : SMAG_W'(cs[0])) : f_s_mag_r;
    f_d_mag_nxt  = en ? (cd[0][ACC_D_W-1] ? DMAG_W'(-cd[0]) : DMAG_W'(cd[0])) : f_d_mag_r;
    f_s_neg_nxt  = en ? cs[0][ACC_S_W-1] : f_s_neg_r;
    f_d_neg_nxt  = en ? cd[0][ACC_D_W-1] : f_d_neg_r;
    f_mean_nxt   = en ? e_mean_r : f_mean_r;
    f_v_nxt      = en ? e_v_r : f_v_r;
    g_s_prod_nxt = en ? SPROD_W'(f_s_mag_r) * SPROD_W'(S_MUL) : g_s_prod_r;
    g_d_prod_nxt = en ? DPROD_W'(f_d_mag_r) * DPROD_W'(D_MUL) : g_d_prod_r;
    g_s_neg_nxt  = en ? f_s_neg_r : g_s_neg_r;
    g_d_neg_nxt  = en ? f_d_neg_r : g_d_neg_r;
    g_mean_nxt   = en ? f_mean_r : g_mean_r;
    g_v_nxt      = en ? f_v_r : g_v_r;
  end

  always_comb begin
    smooth  = sat_signed(64'(g_s_prod_r[SPROD_W-1:S_SH]), g_s_neg_r);
    deriv   = sat_signed(64'(g_d_prod_r[DPROD_W-1:D_SH]), g_d_neg_r);
    h_shift = g_v_r && en;
    for (int i = 0; i < HIST_LEN; i++) begin
      hist_nxt[i] = hist_r[i];
    end
    if (h_shift) begin
      for (int i = HIST_LEN - 1; i > 0; i--) begin
        hist_nxt[i] = hist_r[i-1];
      end
      hist_nxt[0] = (rate_r > RATE_W'(RATE_LIMIT)) ? g_mean_r : smooth;
    end
    out_avg_nxt = h_shift ? g_mean_r : out_avg_r;
    out_sm_nxt  = h_shift ? hist_r[HIST_LEN-1] : out_sm_r;
    out_dv_nxt  = h_shift ? deriv : out_dv_r;
    out_v_nxt   = en ? g_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= '0;
      sum_r   <= '0;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      e_v_r   <= 1'b0;
      f_v_r   <= 1'b0;
      g_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      rate_r  <= rate_nxt;
      sum_r   <= sum_nxt;
      a_v_r   <= a_v_nxt;
      b_v_r   <= b_v_nxt;
      c_v_r   <= c_v_nxt;
      d_v_r   <= d_v_nxt;
      e_v_r   <= e_v_nxt;
      f_v_r   <= f_v_nxt;
      g_v_r   <= g_v_nxt;
      out_v_r <= out_v_nxt;
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    b_mag_r    <= b_mag_nxt;
    b_neg_r    <= b_neg_nxt;
    c_prod_r   <= c_prod_nxt;
    c_neg_r    <= c_neg_nxt;
    d_mean_r   <= d_mean_nxt;
    e_mean_r   <= e_mean_nxt;
    f_s_mag_r  <= f_s_mag_nxt;
    f_d_mag_r  <= f_d_mag_nxt;
    f_s_neg_r  <= f_s_neg_nxt;
    f_d_neg_r  <= f_d_neg_nxt;
    f_mean_r   <= f_mean_nxt;
    g_s_prod_r <= g_s_prod_nxt;
    g_d_prod_r <= g_d_prod_nxt;
    g_s_neg_r  <= g_s_neg_nxt;
    g_d_neg_r  <= g_d_neg_nxt;
    g_mean_r   <= g_mean_nxt;
    out_avg_r  <= out_avg_nxt;
    out_sm_r   <= out_sm_nxt;
    out_dv_r   <= out_dv_nxt;
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.moving_average   = out_avg_r;
  assign out_ch.smoothed_delayed = out_sm_r;
  assign out_ch.first_derivative = out_dv_r;

  `MAS_ASSERT_IMP(a_ready_when_empty, !out_v_r, in_ch.ready, "input held off with empty output")
  `MAS_ASSERT_NXT(a_result_moves, !out_v_r && g_v_r, out_v_r, "result lost before output register")
  `MAS_ASSERT_IMP(a_mean_range, d_v_r, (d_mean_r <= OUT_W'(OUT_LIMIT)) && (d_mean_r >= -OUT_W'(OUT_LIMIT)), "mean out of range")
  `MAS_ASSERT_NXT(a_stall_freezes, out_v_r && !out_ch.ready && g_v_r, g_v_r && $stable(g_mean_r), "pipeline moved during stall")

endmodule

`default_nettype wire

// File: sv/mas_sample_cell.sv
// one entry of the negated sample window, passes its value to the next cell
// depends on mas_pkg
`default_nettype none

module mas_sample_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              shift,
  input  logic signed [mas_pkg::NEG_W-1:0]  d_in,
  output logic signed [mas_pkg::NEG_W-1:0]  q
);
  import mas_pkg::*;

  logic signed [NEG_W-1:0] q_r, q_nxt;

  always_comb q_nxt = shift ? d_in : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// File: sv/mas_sg_cell.sv
// one tap of the transposed savitzky-golay filter, smoothing and derivative
// depends on mas_pkg
`default_nettype none

module mas_sg_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                shift,
  input  logic signed [mas_pkg::OUT_W-1:0]    x,
  input  logic signed [mas_pkg::TAP_W-1:0]    tap_s,
  input  logic signed [mas_pkg::TAP_W-1:0]    tap_d,
  input  logic signed [mas_pkg::ACC_S_W-1:0]  acc_s_in,
  input  logic signed [mas_pkg::ACC_D_W-1:0]  acc_d_in,
  output logic signed [mas_pkg::ACC_S_W-1:0]  acc_s,
  output logic signed [mas_pkg::ACC_D_W-1:0]  acc_d
);
  import mas_pkg::*;

  logic signed [OUT_W+TAP_W-1:0] prod_s, prod_d;
  logic signed [ACC_S_W-1:0]     acc_s_r, acc_s_nxt;
  logic signed [ACC_D_W-1:0]     acc_d_r, acc_d_nxt;

  always_comb begin
    prod_s    = x * tap_s;
    prod_d    = x * tap_d;
    acc_s_nxt = shift ? acc_s_in + ACC_S_W'(prod_s) : acc_s_r;
    acc_d_nxt = shift ? acc_d_in + ACC_D_W'(prod_d) : acc_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_s_r <= '0;
      acc_d_r <= '0;
    end else begin
      acc_s_r <= acc_s_nxt;
      acc_d_r <= acc_d_nxt;
    end
  end

  assign acc_s = acc_s_r;
  assign acc_d = acc_d_r;

endmodule

`default_nettype wire

// File: sim/tb_moving_average_savgol_smoother.sv
// testbench for moving_average_savgol_smoother: random and directed depth samples
// against a scoreboard that predicts the mean, smoothed and derivative results
// depends on mas_pkg, mas_in_if, mas_out_if, mas_cfg_if and the smoother rtl
`timescale 1ns / 100ps

module tb_moving_average_savgol_smoother;
  import mas_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_AFTER   = 300;
  localparam int PHASE_ITEMS  = 105;
  localparam int NUM_PHASES   = 6;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_PRINTED  = 30;
  localparam int SMOOTH_TAP [SG_TAPS] = '{-21, 14, 39, 54, 59, 54, 39, 14, -21};

  typedef enum int {
    SEG_LEVEL,
    SEG_RAMP,
    SEG_TOGGLE,
    SEG_NOISE,
    SEG_SQUARE
  } segment_kind_t;

  typedef struct {
    logic signed [OUT_W-1:0] moving_average;
    logic signed [OUT_W-1:0] smoothed_delayed;
    logic signed [OUT_W-1:0] first_derivative;
  } smoother_result_t;

  class smoother_scoreboard;
    logic signed [NEG_W-1:0] neg_win [AVG_LEN];
    logic signed [OUT_W-1:0] mean_win [SG_TAPS];
    logic signed [OUT_W-1:0] smooth_hist [HIST_LEN];
    logic [RATE_W-1:0]       rate;
    smoother_result_t        expected_q [$];
    int                      errors;
    int                      checked;

    function new();
      foreach (neg_win[i]) neg_win[i] = '0;
      foreach (mean_win[i]) mean_win[i] = '0;
      foreach (smooth_hist[i]) smooth_hist[i] = '0;
      rate    = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function logic signed [OUT_W-1:0] fit_out(longint v);
      if (v > OUT_LIMIT) return OUT_W'(OUT_LIMIT);
      if (v < -OUT_LIMIT) return OUT_W'(-OUT_LIMIT);
      return OUT_W'(v);
    endfunction

    function void set_rate(logic [RATE_W-1:0] v);
      rate = v;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      longint neg;
      longint sum;
      longint acc_s;
      longint acc_d;
      logic signed [OUT_W-1:0] avg;
      smoother_result_t want;
      neg = -longint'(s);
      if (neg > NEG_MAX) neg = NEG_MAX;
      for (int i = AVG_LEN - 1; i > 0; i--) neg_win[i] = neg_win[i-1];
      neg_win[0] = NEG_W'(neg);
      sum = 0;
      foreach (neg_win[i]) sum += longint'(neg_win[i]);
      avg = fit_out((sum * (longint'(1) << FRAC_BITS)) / AVG_LEN);
      for (int i = SG_TAPS - 1; i > 0; i--) mean_win[i] = mean_win[i-1];
      mean_win[0] = avg;
      acc_s = 0;
      acc_d = 0;
      for (int i = 0; i < SG_TAPS; i++) begin
        acc_s += longint'(SMOOTH_TAP[i]) * longint'(mean_win[i]);
        acc_d += longint'(4 - i) * longint'(mean_win[i]);
      end
      want.moving_average   = avg;
      want.smoothed_delayed = smooth_hist[HIST_LEN-1];
      want.first_derivative = fit_out(acc_d / SG_D_DIV);
      for (int i = HIST_LEN - 1; i > 0; i--) smooth_hist[i] = smooth_hist[i-1];
      smooth_hist[0] = (rate > RATE_LIMIT) ? avg : fit_out(acc_s / SG_S_DIV);
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("%s", msg);
    endtask

    task compare_field(string name, logic signed [OUT_W-1:0] got,
                       logic signed [OUT_W-1:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is %0d, predicted %0d", checked, name, got, want));
    endtask

    task check_result(smoother_result_t got);
      smoother_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no sample request waiting", checked));
      end else begin
        want = expected_q[0];
        expected_q.delete(0);
        compare_field("moving_average", got.moving_average, want.moving_average);
        compare_field("smoothed_delayed", got.smoothed_delayed, want.smoothed_delayed);
        compare_field("first_derivative", got.first_derivative, want.first_derivative);
      end
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d predicted results never arrived", expected_q.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;

  mas_in_if  in_ch ();
  mas_out_if out_ch ();
  mas_cfg_if cfg_ch ();

  moving_average_savgol_smoother uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  smoother_scoreboard sb;
  int samples_taken;
  int results_seen;
  int rate_writes;
  int hold_seen;
  bit busy_mode;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int clip_sample(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic send_sample(int v);
    int gap;
    gap = busy_mode ? 0 : pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.sample = SAMPLE_W'(v);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic end_samples();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_rate(logic [RATE_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid         = 1'b1;
    cfg_ch.mean_rate_bpm = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    rate_writes++;
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int count);
    segment_kind_t kind;
    int sent;
    int len;
    int v;
    int step;
    sent = 0;
    while (sent < count) begin
      kind      = segment_kind_t'($urandom_range(0, 4));
      busy_mode = ($urandom_range(0, 3) == 0);
      case (kind)
        SEG_LEVEL: begin
          len = $urandom_range(25, 40);
          v   = pick_level();
          repeat (len) send_sample(v);
        end
        SEG_RAMP: begin
          len  = $urandom_range(10, 30);
          v    = int'($signed(16'($urandom)));
          step = int'($urandom_range(0, 8000)) - 4000;
          repeat (len) begin
            send_sample(v);
            v = clip_sample(v + step);
          end
        end
        SEG_TOGGLE: begin
          len = $urandom_range(5, 20);
          for (int i = 0; i < len; i++) send_sample((i % 2) ? 32767 : -32768);
        end
        SEG_NOISE: begin
          len = $urandom_range(5, 20);
          repeat (len) send_sample(int'($signed(16'($urandom))));
        end
        default: begin
          len = $urandom_range(25, 35);
          v   = $urandom_range(0, 1) ? 32767 : -32768;
          repeat (len) send_sample(v);
          repeat (len) send_sample(-v - 1);
          len = 2 * len;
        end
      endcase
      sent += len;
    end
    busy_mode = 1'b0;
  endtask

  // result side with random stalls and one long hold-off
  initial begin : result_sink
    int n;
    bit held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held         = 1'b1;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_seen = HOLD_CYCLES;
      end else begin
        n = pick_gap();
        if (n != 0) begin
          out_ch.ready = 1'b0;
          repeat (n) @(negedge clk);
        end
      end
      out_ch.ready = 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  always @(posedge clk) begin : monitor
    smoother_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.moving_average   = out_ch.moving_average;
        got.smoothed_delayed = out_ch.smoothed_delayed;
        got.first_derivative = out_ch.first_derivative;
        sb.check_result(got);
        results_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_sample(in_ch.sample);
        samples_taken++;
      end
      if (cfg_ch.valid && cfg_ch.ready) sb.set_rate(cfg_ch.mean_rate_bpm);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int phase_rate [NUM_PHASES];
    int directed [7];
    sb                   = new();
    samples_taken        = 0;
    results_seen         = 0;
    rate_writes          = 0;
    hold_seen            = 0;
    busy_mode            = 1'b0;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.sample         = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.mean_rate_bpm = '0;
    phase_rate = '{61, 60, 255, 0, 0, 0};
    phase_rate[4] = $urandom_range(0, 255);
    phase_rate[5] = $urandom_range(0, 255);
    directed = '{-32768, 32767, 0, -1, 1, 16'sh5555, -21846};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // warm-up from zero windows, extremes, then a run at the most negative sample
    write_rate(8'd0);
    foreach (directed[i]) send_sample(directed[i]);
    repeat (18) send_sample(-32768);
    end_samples();
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_rate(RATE_W'(phase_rate[p]));
      run_random(PHASE_ITEMS);
      end_samples();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();
    $display("%0d samples over %0d rate settings, %0d results checked, %0d mismatches",
             samples_taken, rate_writes, results_seen, sb.errors);
    $display("output held off for %0d cycles while samples kept coming", hold_seen);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
